// File: hdl/rgb_median_filter_3x3_defines.svh
// Assertion macros used by the median filter top level.
`ifndef RGB_MEDIAN_FILTER_3X3_DEFINES_SVH
`define RGB_MEDIAN_FILTER_3X3_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RMF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define RMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rmf_pkg.sv
// Types, constants and the median network shared by the median filter modules.
package rmf_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_W    = 16;
   localparam int EFFW_W      = (ADDR_W + 1 > WIDTH_REG_W) ? ADDR_W + 1 : WIDTH_REG_W;
   localparam int PEND_W      = $clog2(MAX_WIDTH + 2);
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int DATA_W      = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = HEIGHT_W'(480);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   // Word kinds on req_tuser
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // Compare-exchange network for the median of nine (low slot takes the min)
   localparam int MED_STEPS = 19;
   localparam logic [3:0] MED_LO [MED_STEPS] =
      '{4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
        4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
   localparam logic [3:0] MED_HI [MED_STEPS] =
      '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
        4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

   typedef logic [PIX_W-1:0] pix_type;

   // Word leaving the position control toward the line stores
   typedef struct packed {
      logic              flush;
      logic              produce;
      logic              border;
      logic              frame_end;
      logic              sel_upper;
      logic [ADDR_W-1:0] addr;
      pix_type           pix;
   } item_type;

   // Window column leaving the line stores; a flush word carries its value in col_mid
   typedef struct packed {
      logic    flush;
      logic    produce;
      logic    border;
      logic    frame_end;
      pix_type col_top;
      pix_type col_mid;
      pix_type col_bot;
   } column_type;

   // Position status for checking
   typedef struct packed {
      logic [ADDR_W-1:0]   col;
      logic [HEIGHT_W-1:0] row;
      logic [PEND_W-1:0]   pending;
      logic [EFFW_W-1:0]   eff_w;
   } pos_status_type;

   function automatic logic [CHAN_W-1:0] median9(input logic [9*CHAN_W-1:0] vals);
      logic [CHAN_W-1:0] p [9];
      logic [CHAN_W-1:0] t;
      for (int i = 0; i < 9; i++) begin
         p[i] = vals[i*CHAN_W +: CHAN_W];
      end
      for (int s = 0; s < MED_STEPS; s++) begin
         if (p[MED_LO[s]] > p[MED_HI[s]]) begin
            t            = p[MED_LO[s]];
            p[MED_LO[s]] = p[MED_HI[s]];
            p[MED_HI[s]] = t;
         end
      end
      return p[4];
   endfunction

endpackage

// File: hdl/rmf_pos_ctrl.sv
// Frame geometry registers, pixel position counters and flush bookkeeping.
module rmf_pos_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [rmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rmf_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            accept,
   input  logic                            req_mode,
   input  rmf_pkg::pix_type                req_pix,
   output rmf_pkg::item_type               item,
   output logic                            item_valid,
   output rmf_pkg::pos_status_type         status
);
   import rmf_pkg::*;

   logic [WIDTH_REG_W-1:0] width_ff;
   logic [HEIGHT_W-1:0]    height_ff;
   logic [ADDR_W-1:0]      col_ff, col_in;
   logic [HEIGHT_W-1:0]    row_ff, row_in;
   logic [PEND_W-1:0]      pend_ff, pend_in;

   logic [EFFW_W-1:0]   eff_w, w_ext, c_ext, c_next, ocol, p_ext, faddr;
   logic [HEIGHT_W-1:0] eff_h, r, orow;
   logic [ADDR_W-1:0]   c;
   logic [HEIGHT_W:0]   r_next;
   logic                produce, interior, col_wrap, row_wrap, sel_upper;

   // Saturate geometry
   always_comb begin
      w_ext = EFFW_W'(width_ff);
      if (w_ext == '0) begin
         eff_w = EFFW_W'(1);
      end else if (w_ext > EFFW_W'(MAX_WIDTH)) begin
         eff_w = EFFW_W'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
      eff_h = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   end

   // Position of this pixel and of the pixel it releases
   always_comb begin
      c     = (EFFW_W'(col_ff) >= eff_w) ? '0 : col_ff;
      r     = (row_ff >= eff_h) ? '0 : row_ff;
      c_ext = EFFW_W'(c);
      produce = (r >= HEIGHT_W'(2)) || (r == HEIGHT_W'(1) && c != '0);
      if (c != '0) begin
         orow = r - HEIGHT_W'(1);
         ocol = c_ext - EFFW_W'(1);
      end else begin
         orow = r - HEIGHT_W'(2);
         ocol = eff_w - EFFW_W'(1);
      end
      interior = (orow != '0) && (ocol != '0)
                 && ({1'b0, ocol} + (EFFW_W+1)'(2) <= {1'b0, eff_w})
                 && ({1'b0, orow} + (HEIGHT_W+1)'(2) <= {1'b0, eff_h});
      c_next   = c_ext + EFFW_W'(1);
      col_wrap = c_next >= eff_w;
      r_next   = {1'b0, r} + (HEIGHT_W+1)'(1);
      row_wrap = r_next >= {1'b0, eff_h};
   end

   // Flush read address: lower store for the last row, upper store for its pad pixel
   always_comb begin
      p_ext     = EFFW_W'(pend_ff);
      sel_upper = p_ext > eff_w;
      faddr     = sel_upper ? (eff_w - EFFW_W'(1)) : (eff_w - p_ext);
   end

   // Build the word for the line stores
   always_comb begin
      item_valid     = (req_mode == MODE_PIXEL) || (pend_ff != '0);
      item.pix       = req_pix;
      if (req_mode == MODE_FLUSH) begin
         item.flush     = 1'b1;
         item.produce   = 1'b1;
         item.border    = 1'b0;
         item.frame_end = (pend_ff == PEND_W'(1));
         item.sel_upper = sel_upper;
         item.addr      = faddr[ADDR_W-1:0];
      end else begin
         item.flush     = 1'b0;
         item.produce   = produce;
         item.border    = !interior;
         item.frame_end = 1'b0;
         item.sel_upper = 1'b0;
         item.addr      = c;
      end
   end

   // Next counter values
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (csr_valid) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = '0;
      end else if (accept && req_mode == MODE_PIXEL) begin
         col_in  = col_wrap ? '0 : c_next[ADDR_W-1:0];
         row_in  = col_wrap ? (row_wrap ? '0 : r_next[HEIGHT_W-1:0]) : r;
         pend_in = '0;
         if (col_wrap && row_wrap) begin
            pend_in = (eff_h >= HEIGHT_W'(2)) ? PEND_W'(eff_w) + PEND_W'(1)
                                              : PEND_W'(eff_w);
         end
      end else if (accept && pend_ff != '0) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   // Hold geometry and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         if (csr_valid && csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_data[WIDTH_REG_W-1:0];
         end
         if (csr_valid && csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr_data[HEIGHT_W-1:0];
         end
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
      end
   end

   assign status.col     = col_ff;
   assign status.row     = row_ff;
   assign status.pending = pend_ff;
   assign status.eff_w   = eff_w;

endmodule

// File: hdl/rmf_line_buf.sv
// Two line stores with registered reads and write forwarding; emits one window column.
module rmf_line_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rmf_pkg::item_type    item,
   input  logic                 s2_free,
   output logic                 s1_free,
   output logic                 col_valid,
   output rmf_pkg::column_type  column
);
   import rmf_pkg::*;

   pix_type  mem_upper [MAX_WIDTH];
   pix_type  mem_lower [MAX_WIDTH];
   pix_type  rd_upper_ff, rd_lower_ff;
   pix_type  fwd_upper_ff, fwd_lower_ff;
   logic     fwd_hit_ff;
   item_type s1_ff;
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_mv;
   pix_type  upper_val, lower_val;

   assign s1_mv   = s1_valid_ff && s2_free;
   assign s1_free = !s1_valid_ff || s2_free;

   // Take the value written by the word ahead when it hit the same entry
   assign upper_val = fwd_hit_ff ? fwd_upper_ff : rd_upper_ff;
   assign lower_val = fwd_hit_ff ? fwd_lower_ff : rd_lower_ff;

   // Upper store: shift the lower row up on each pixel
   always_ff @(posedge clock) begin
      if (s1_mv && !s1_ff.flush) begin
         mem_upper[s1_ff.addr] <= lower_val;
      end
      if (load) begin
         rd_upper_ff <= mem_upper[item.addr];
      end
   end

   // Lower store: take the new pixel
   always_ff @(posedge clock) begin
      if (s1_mv && !s1_ff.flush) begin
         mem_lower[s1_ff.addr] <= s1_ff.pix;
      end
      if (load) begin
         rd_lower_ff <= mem_lower[item.addr];
      end
   end

   // Stage payload and forwarding data
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff        <= item;
         fwd_upper_ff <= lower_val;
         fwd_lower_ff <= s1_ff.pix;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_mv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (load) begin
            fwd_hit_ff <= s1_mv && !s1_ff.flush && (s1_ff.addr == item.addr);
         end
      end
   end

   // Column toward the window
   always_comb begin
      col_valid        = s1_mv;
      column.flush     = s1_ff.flush;
      column.produce   = s1_ff.produce;
      column.border    = s1_ff.border;
      column.frame_end = s1_ff.frame_end;
      column.col_top   = upper_val;
      column.col_bot   = s1_ff.pix;
      if (s1_ff.flush) begin
         column.col_mid = s1_ff.sel_upper ? upper_val : lower_val;
      end else begin
         column.col_mid = lower_val;
      end
   end

endmodule

// File: hdl/rmf_window_med.sv
// 3x3 window registers, per-channel median network and the result register.
module rmf_window_med (
   input  logic                clock,
   input  logic                reset,
   input  logic                col_valid,
   input  rmf_pkg::column_type column,
   input  logic                rsp_tready,
   output logic                s2_free,
   output logic                s2_valid,
   output logic                rsp_tvalid,
   output rmf_pkg::pix_type    rsp_pix,
   output logic                rsp_last
);
   import rmf_pkg::*;

   pix_type win_ff [3][3];
   logic    s2_valid_ff, s2_valid_in;
   logic    s2_flush_ff, s2_produce_ff, s2_border_ff, s2_last_ff;
   pix_type s2_flush_pix_ff;
   logic    rsp_valid_ff;
   pix_type rsp_pix_ff;
   logic    rsp_last_ff;
   logic    out_free, out_load;

   logic [9*CHAN_W-1:0] red_set, green_set, blue_set;
   pix_type             med_pix, result_pix;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign out_load = s2_valid_ff && s2_produce_ff && out_free;

   // Shift the window left and insert the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (col_valid && !column.flush) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= column.col_top;
         win_ff[1][2] <= column.col_mid;
         win_ff[2][2] <= column.col_bot;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (col_valid) begin
         s2_flush_ff     <= column.flush;
         s2_produce_ff   <= column.produce;
         s2_border_ff    <= column.border;
         s2_last_ff      <= column.frame_end;
         s2_flush_pix_ff <= column.col_mid;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (col_valid) begin
         s2_valid_in = 1'b1;
      end else if (out_free) begin
         s2_valid_in = 1'b0;
      end
   end

   // Gather the nine samples of each channel
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         red_set[i*CHAN_W +: CHAN_W]   = win_ff[i/3][i%3][PIX_W-1 -: CHAN_W];
         green_set[i*CHAN_W +: CHAN_W] = win_ff[i/3][i%3][CHAN_W +: CHAN_W];
         blue_set[i*CHAN_W +: CHAN_W]  = win_ff[i/3][i%3][0 +: CHAN_W];
      end
      med_pix = {median9(red_set), median9(green_set), median9(blue_set)};
      if (s2_flush_ff) begin
         result_pix = s2_flush_pix_ff;
      end else if (s2_border_ff) begin
         result_pix = win_ff[1][1];
      end else begin
         result_pix = med_pix;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pix_ff  <= result_pix;
         rsp_last_ff <= s2_last_ff;
      end
   end

   // Stage and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff && s2_produce_ff;
         end
      end
   end

   assign s2_valid   = s2_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pix    = rsp_pix_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: hdl/rgb_median_filter_3x3.sv
// Top level of the streaming 3x3 RGB median filter.
// A result word passes the line store stage, the window stage and the result register.
// Throughput: one word per cycle while rsp_tready keeps up, set by the single read and write port of each line store.
// A result appears one row plus one pixel after its source pixel; flush words drain the rest.
// Reset (synchronous, active high) clears counters, pipeline valids and the window and sets
// the frame to 640 x 480; the line stores are not cleared and need no clearing pass.
`include "rgb_median_filter_3x3_defines.svh"

module rgb_median_filter_3x3 (
   input  logic                           clock,
   input  logic                           reset,
   // Pixel input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rmf_pkg::DATA_W-1:0]     req_tdata,   // in_red, in_green, in_blue
   input  logic [0:0]                     req_tuser,   // mode
   // Filtered output
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rmf_pkg::DATA_W-1:0]     rsp_tdata,   // out_red, out_green, out_blue
   output logic                           rsp_tlast,   // frame_end
   // Register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rmf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rmf_pkg::CSR_DATA_W-1:0] csr_data
);
   import rmf_pkg::*;

   logic           accept, load, item_valid, s1_free, s2_free, s2_valid, col_valid;
   item_type       item;
   column_type     column;
   pos_status_type status;
   pix_type        req_pix, rsp_pix;

   assign csr_ready  = 1'b1;
   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;
   assign load       = accept && item_valid;
   assign req_pix    = {req_tdata[0 +: CHAN_W], req_tdata[CHAN_W +: CHAN_W],
                        req_tdata[2*CHAN_W +: CHAN_W]};
   assign rsp_tdata  = {rsp_pix[0 +: CHAN_W], rsp_pix[CHAN_W +: CHAN_W],
                        rsp_pix[2*CHAN_W +: CHAN_W]};

   rmf_pos_ctrl u_pos_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .accept     (accept),
      .req_mode   (req_tuser[0]),
      .req_pix    (req_pix),
      .item       (item),
      .item_valid (item_valid),
      .status     (status)
   );

   rmf_line_buf u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .item      (item),
      .s2_free   (s2_free),
      .s1_free   (s1_free),
      .col_valid (col_valid),
      .column    (column)
   );

   rmf_window_med u_window_med (
      .clock      (clock),
      .reset      (reset),
      .col_valid  (col_valid),
      .column     (column),
      .rsp_tready (rsp_tready),
      .s2_free    (s2_free),
      .s2_valid   (s2_valid),
      .rsp_tvalid (rsp_tvalid),
      .rsp_pix    (rsp_pix),
      .rsp_last   (rsp_tlast)
   );

   // Checks on pipeline and counter consistency
   `RMF_ASSERT_NEXT(a_no_phantom_word, !rsp_tvalid && !s2_valid, !rsp_tvalid, "result word without source")
   `RMF_ASSERT_NOW(a_stall_only_backpressure, !req_tready, rsp_tvalid && !rsp_tready, "input stalled without output backpressure")
   `RMF_ASSERT_NOW(a_drain_at_frame_start, status.pending != '0, status.col == '0 && status.row == '0, "drain pending mid frame")
   `RMF_ASSERT_NOW(a_col_in_range, 1'b1, EFFW_W'(status.col) < status.eff_w, "column beyond image width")

endmodule

// File: sim/rgb_median_filter_3x3_tb.sv
// Self-checking testbench for the streaming 3x3 RGB median filter.
`timescale 1ns / 1ps

module rgb_median_filter_3x3_tb;

   localparam int LINE_DEPTH = rmf_pkg::MAX_WIDTH;

   // One filtered output word as the checker sees it
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_end;
   } filtered_pixel_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rmf_pkg::DATA_W-1:0]     req_tdata  = '0;   // in_red, in_green, in_blue
   logic [0:0]                     req_tuser  = '0;   // mode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rmf_pkg::DATA_W-1:0]     rsp_tdata;         // out_red, out_green, out_blue
   logic                           rsp_tlast;         // frame_end
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [rmf_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [rmf_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // Shadow of the filter: frame size, line stores, window and position
   logic [11:0]        size_width;
   logic [15:0]        size_height;
   logic [23:0]        row_two_back [LINE_DEPTH];
   logic [23:0]        row_one_back [LINE_DEPTH];
   logic [23:0]        win [3][3];
   int unsigned        next_col;
   int unsigned        next_row;
   int unsigned        owed_pixels;

   filtered_pixel_type expected_pixels [$];
   int unsigned        mismatches = 0;
   bit                 idle_on    = 1'b1;
   int unsigned        stall_left = 0;

   rgb_median_filter_3x3 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Give up on a hung run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int unsigned frame_width();
      if (size_width == 0) return 1;
      if (size_width > LINE_DEPTH) return LINE_DEPTH;
      return size_width;
   endfunction

   function automatic int unsigned frame_height();
      return (size_height == 0) ? 1 : size_height;
   endfunction

   function automatic void reset_filter_model();
      size_width  = 12'd640;
      size_height = 16'd480;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         row_two_back[i] = '0;
         row_one_back[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      next_col    = 0;
      next_row    = 0;
      owed_pixels = 0;
   endfunction

   // A size write restarts the frame
   function automatic void apply_frame_size(input logic [rmf_pkg::CSR_IDX_W-1:0] index,
                                            input logic [15:0] value);
      if (index == rmf_pkg::REG_IMAGE_WIDTH) size_width = value[11:0];
      else size_height = value;
      next_col    = 0;
      next_row    = 0;
      owed_pixels = 0;
   endfunction

   // Median of one channel over the window: the value with at most four below it
   // and at least five at or below it
   function automatic logic [7:0] window_median(input int lsb);
      logic [7:0] v [9];
      int         below;
      int         not_above;
      for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3][lsb +: 8];
      for (int i = 0; i < 9; i++) begin
         below     = 0;
         not_above = 0;
         for (int j = 0; j < 9; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= 4 && not_above >= 5) return v[i];
      end
      return v[4];
   endfunction

   function automatic void push_pixel(input logic [23:0] pix, input logic last);
      filtered_pixel_type want;
      want.red       = pix[7:0];
      want.green     = pix[15:8];
      want.blue      = pix[23:16];
      want.frame_end = last;
      expected_pixels.push_back(want);
   endfunction

   // Advance the shadow by one accepted word and queue the pixel it releases
   function automatic void predict_filter_output(input logic mode, input logic [23:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned orow;
      int unsigned ocol;
      logic [23:0] val;
      w = frame_width();
      h = frame_height();
      if (mode == rmf_pkg::MODE_FLUSH) begin
         if (owed_pixels == 0) return;
         val = (owed_pixels <= w) ? row_one_back[w - owed_pixels] : row_two_back[w - 1];
         push_pixel(val, owed_pixels == 1);
         owed_pixels--;
         return;
      end
      owed_pixels = 0;
      c = (next_col >= w) ? 0 : next_col;
      r = (next_row >= h) ? 0 : next_row;
      // shift the window left and bring in the new column
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2]       = row_two_back[c];
      win[1][2]       = row_one_back[c];
      win[2][2]       = pix;
      row_two_back[c] = row_one_back[c];
      row_one_back[c] = pix;
      if (r >= 2 || (r == 1 && c >= 1)) begin
         if (c >= 1) begin
            orow = r - 1;
            ocol = c - 1;
         end else begin
            orow = r - 2;
            ocol = w - 1;
         end
         if (orow >= 1 && ocol >= 1 && ocol + 2 <= w && orow + 2 <= h)
            val = {window_median(16), window_median(8), window_median(0)};
         else
            val = win[1][1];
         push_pixel(val, 1'b0);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) begin
            r           = 0;
            owed_pixels = (h >= 2) ? w + 1 : w;
         end
      end
      next_col = c;
      next_row = r;
   endfunction

   // ---------------------------------------------------------------- checking

   // Compare each accepted output word with the oldest expected pixel; stall at random
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected output word: data=%h last=%b", rsp_tdata, rsp_tlast);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.red || rsp_tdata[15:8] !== want.green ||
                   rsp_tdata[23:16] !== want.blue || rsp_tlast !== want.frame_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                              want.red, want.green, want.blue, want.frame_end,
                              rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Send one word, at times with a random gap ahead of it
   task automatic send_word(input logic mode, input logic [23:0] pix);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      // a flush word carries junk data, which must be ignored
      req_tdata  <= (mode == rmf_pkg::MODE_FLUSH) ? 24'($urandom) : pix;
      do @(posedge clock); while (!req_tready);
      predict_filter_output(mode, pix);
   endtask

   // Hold the input until every expected pixel is out and the pipeline is empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rmf_pkg::CSR_IDX_W-1:0] index, input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_frame_size(index, value);
   endtask

   function automatic logic [23:0] random_pixel();
      logic [7:0] corner [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      if ($urandom_range(0, 3) != 0) return 24'($urandom);
      return {corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
              corner[$urandom_range(0, 5)]};
   endfunction

   task automatic send_pixels(input int unsigned count);
      repeat (count) send_word(rmf_pkg::MODE_PIXEL, random_pixel());
   endtask

   task automatic send_flushes(input int unsigned count);
      repeat (count) send_word(rmf_pkg::MODE_FLUSH, 24'd0);
   endtask

   // ---------------------------------------------------------------- tests

   // Power-up frame is 640 wide: the first pixel comes out after one row plus one
   task automatic test_reset_defaults();
      send_pixels(644);
   endtask

   // 3x3 frame of extreme values: one true median, eight border pixels, frame end
   task automatic test_directed_frame();
      logic [23:0] corners [9] = '{24'h000000, 24'hFFFFFF, 24'h55AA55, 24'hAA55AA,
                                   24'h0F0F0F, 24'hF0F0F0, 24'h010203, 24'hFEFDFC,
                                   24'h807F80};
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd3);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd3);
      foreach (corners[i]) send_word(rmf_pkg::MODE_PIXEL, corners[i]);
      // four owed pixels, then a flush with nothing left
      send_flushes(5);
   endtask

   // Sizes at and beyond their limits
   task automatic test_size_limits();
      // zero size saturates to a one pixel frame
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd0);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd0);
      send_pixels(1);
      send_flushes(2);
      // upper bits of the width word are dropped; tallest frame, cut short
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'hF003);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
      send_pixels(18);
      // widest row, abandoned early in the second row
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd2048);
      send_pixels(LINE_DEPTH + 12);
      // oversize width saturates to the line store depth
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'h0FFF);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd2);
      send_pixels(LINE_DEPTH + 8);
   endtask

   // Next frame started while output is still owed, plus one and two row frames
   task automatic test_frame_restart();
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd4);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd3);
      send_pixels(12);
      send_flushes(2);
      send_pixels(12);
      send_flushes(7);
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd5);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd1);
      send_pixels(5);
      send_flushes(6);
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd2);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd2);
      send_pixels(4);
      send_flushes(3);
   endtask

   // A register write mid-frame drops the frame and restarts at the top
   task automatic test_abandoned_frame();
      write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'd5);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd4);
      send_pixels(7);
      write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'd4);
      send_pixels(20);
      send_flushes(6);
   endtask

   // Mostly whole frames of random sizes, some cut short or drained only in part
   task automatic test_random_frames(input int unsigned items_wanted);
      int unsigned sent;
      int unsigned w;
      int unsigned h;
      int unsigned npix;
      int unsigned nflush;
      int unsigned shape;
      bit          first;
      sent  = 0;
      first = 1'b1;
      while (sent < items_wanted) begin
         // the tail of the run goes without idling
         idle_on = (sent + 300 < items_wanted) && ($urandom_range(0, 4) != 0);
         if (first || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0:       w = $urandom_range(13, 48);
               1:       w = $urandom_range(1, 2);
               default: w = $urandom_range(3, 10);
            endcase
            case ($urandom_range(0, 9))
               0:       h = $urandom_range(9, 16);
               1:       h = $urandom_range(1, 2);
               default: h = $urandom_range(3, 6);
            endcase
            if ($urandom_range(0, 1) == 0) begin
               write_reg(rmf_pkg::REG_IMAGE_WIDTH, (w == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(w));
               write_reg(rmf_pkg::REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(h));
            end else begin
               write_reg(rmf_pkg::REG_IMAGE_HEIGHT, 16'(h));
               write_reg(rmf_pkg::REG_IMAGE_WIDTH, 16'(w));
            end
            first = 1'b0;
         end
         shape = $urandom_range(0, 9);
         npix  = (shape == 0) ? $urandom_range(1, w * h) : w * h;
         for (int i = 0; i < npix; i++) begin
            send_word(rmf_pkg::MODE_PIXEL, random_pixel());
            // now and then let the output run dry mid-frame
            if ($urandom_range(0, 299) == 0) wait_drained();
         end
         sent += npix;
         nflush = owed_pixels;
         if (shape == 1 && nflush > 0) nflush = $urandom_range(0, nflush - 1);
         sent += nflush;
         if (shape == 2 || owed_pixels == 0) nflush += $urandom_range(0, 2);
         send_flushes(nflush);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_filter_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_frame();
      test_size_limits();
      test_frame_restart();
      test_abandoned_frame();
      test_random_frames(1400);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rmf_pkg.sv
hdl/rmf_pos_ctrl.sv
hdl/rmf_line_buf.sv
hdl/rmf_window_med.sv
hdl/rgb_median_filter_3x3.sv
sim/rgb_median_filter_3x3_tb.sv
